>>> rtl/wrlt_pkg.sv
// Shared types and constants for the wakeup-to-run latency table.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package wrlt_pkg;

	localparam int TASK_W           = 22;
	localparam int TIME_W           = 64;
	localparam int CFG_W            = 32;
	localparam int TABLE_SLOTS_DFLT = 64;

	localparam logic [CFG_W-1:0] MIN_DELAY_RST = 32'd1000;

	localparam logic KIND_WAKEUP = 1'b0;
	localparam logic KIND_SWITCH = 1'b1;

	typedef struct packed {
		logic              valid;
		logic [TASK_W-1:0] task_id;
	} tag_t;

	typedef struct packed {
		logic clr_wr;
		logic load_item;
		logic scan;
		logic commit;
		logic calc;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic scan_done;
		logic kind;
		logic hit;
		logic pass;
		logic out_free;
	} sts_t;

endpackage

>>> rtl/wakeup_to_run_latency_table_top.sv
// Top level of the wakeup-to-run latency table.
// Instantiates wrlt_ctrl and wrlt_dp; depends on wrlt_pkg.
`timescale 1ns / 1ps

// The table maps task ids to wakeup times in a memory of TABLE_SLOTS entries
// that is searched one slot per clock through its single read port. After
// reset the block clears every slot of the table and accepts no transaction
// until that pass ends. A transaction's search then stops at the slot that
// holds its id, or else runs on to the last slot. A finished report waits in
// the output register while the next transaction is accepted. A switch that
// produces a report while an earlier report still waits stays in its last
// cycle until out_ready takes the earlier one.
module wakeup_to_run_latency_table_top
	import wrlt_pkg::*;
#(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DFLT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  logic [TASK_W-1:0] task_id,
	input  logic [TIME_W-1:0] now_ns,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [TASK_W-1:0] out_task_id,
	output logic [TIME_W-1:0] delay_ns,
	output logic [TIME_W-1:0] event_time_ns
);

	cmd_t cmd;
	sts_t sts;

	wrlt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wrlt_dp #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.kind          (kind),
		.task_id       (task_id),
		.now_ns        (now_ns),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_task_id   (out_task_id),
		.delay_ns      (delay_ns),
		.event_time_ns (event_time_ns)
	);

endmodule

>>> rtl/wrlt_ctrl.sv
// Controller state machine for the wakeup-to-run latency table.
// Depends on wrlt_pkg for the command and status structs.
`timescale 1ns / 1ps

module wrlt_ctrl
	import wrlt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_CALC   = 3'd4;
	localparam logic [2:0] ST_EMIT   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.commit = 1'b1;
				if (sts.kind == KIND_SWITCH && sts.hit) begin
					state_d = ST_CALC;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (!sts.pass) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/wrlt_dp.sv
// Datapath for the wakeup-to-run latency table: tag and time memories,
// slot scan, delay arithmetic and the output register. Depends on wrlt_pkg.
`timescale 1ns / 1ps

module wrlt_dp
	import wrlt_pkg::*;
#(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DFLT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              kind,
	input  logic [TASK_W-1:0] task_id,
	input  logic [TIME_W-1:0] now_ns,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [TASK_W-1:0] out_task_id,
	output logic [TIME_W-1:0] delay_ns,
	output logic [TIME_W-1:0] event_time_ns
);

	localparam int IDX_W = $clog2(TABLE_SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

	tag_t              tag_mem  [TABLE_SLOTS];
	logic [TIME_W-1:0] time_mem [TABLE_SLOTS];

	logic [CFG_W-1:0]  min_delay_q;
	logic              kind_q;
	logic [TASK_W-1:0] id_q;
	logic [TIME_W-1:0] now_q;

	logic [IDX_W-1:0]  clr_q;
	logic [IDX_W-1:0]  iss_q;
	logic              iss_done_q;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  addr_s1;
	tag_t              tag_s1;

	logic              hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic              free_q;
	logic [IDX_W-1:0]  free_idx_q;

	logic [TIME_W-1:0] trd_q;
	logic [TIME_W-1:0] delay_q;
	logic              pass_q;

	logic              out_valid_q;
	logic [TASK_W-1:0] out_task_id_q;
	logic [TIME_W-1:0] delay_ns_q;
	logic [TIME_W-1:0] event_time_ns_q;

	logic              cmp_hit;
	logic              cmp_free;
	logic              tag_we;
	logic [IDX_W-1:0]  tag_waddr;
	tag_t              tag_wdata;
	logic              time_we;
	logic [IDX_W-1:0]  time_waddr;
	logic [TIME_W-1:0] delay_d;

	assign cmp_hit  = rd_vld_s1 && tag_s1.valid && (tag_s1.task_id == id_q);
	assign cmp_free = rd_vld_s1 && !tag_s1.valid;
	assign delay_d  = now_q - trd_q;

	assign sts.clr_last  = (clr_q == LAST_IDX);
	assign sts.scan_done = rd_vld_s1 && ((addr_s1 == LAST_IDX) || cmp_hit);
	assign sts.kind      = kind_q;
	assign sts.hit       = hit_q;
	assign sts.pass      = pass_q;
	assign sts.out_free  = !out_valid_q || out_ready;

	always_comb begin
		tag_we    = 1'b0;
		tag_waddr = clr_q;
		tag_wdata = '0;
		if (cmd.clr_wr) begin
			tag_we = 1'b1;
		end else if (cmd.commit) begin
			if (kind_q == KIND_WAKEUP && !hit_q && free_q) begin
				tag_we            = 1'b1;
				tag_waddr         = free_idx_q;
				tag_wdata.valid   = 1'b1;
				tag_wdata.task_id = id_q;
			end else if (kind_q == KIND_SWITCH && hit_q) begin
				tag_we    = 1'b1;
				tag_waddr = hit_idx_q;
			end
		end
	end

	always_comb begin
		time_we    = cmd.commit && (kind_q == KIND_WAKEUP) && (hit_q || free_q);
		time_waddr = hit_q ? hit_idx_q : free_idx_q;
	end

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[tag_waddr] <= tag_wdata;
		end
		if (cmd.scan && !iss_done_q) begin
			tag_s1  <= tag_mem[iss_q];
			addr_s1 <= iss_q;
		end
	end

	always_ff @(posedge clk) begin
		if (time_we) begin
			time_mem[time_waddr] <= now_q;
		end
		if (cmd.commit) begin
			trd_q <= time_mem[hit_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q <= kind;
			id_q   <= task_id;
			now_q  <= now_ns;
		end
		if (cmd.scan && cmp_hit && !hit_q) begin
			hit_idx_q <= addr_s1;
		end
		if (cmd.scan && cmp_free && !free_q) begin
			free_idx_q <= addr_s1;
		end
		if (cmd.calc) begin
			delay_q <= delay_d;
		end
		if (cmd.emit) begin
			out_task_id_q   <= id_q;
			delay_ns_q      <= delay_q;
			event_time_ns_q <= now_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_delay_q <= MIN_DELAY_RST;
			clr_q       <= '0;
			iss_q       <= '0;
			iss_done_q  <= 1'b0;
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				min_delay_q <= cfg_wdata;
			end
			if (cmd.clr_wr) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (cmd.load_item) begin
				iss_q      <= '0;
				iss_done_q <= 1'b0;
				rd_vld_s1  <= 1'b0;
				hit_q      <= 1'b0;
				free_q     <= 1'b0;
			end else if (cmd.scan) begin
				rd_vld_s1 <= !iss_done_q;
				if (!iss_done_q) begin
					iss_q <= iss_q + IDX_W'(1);
					if (iss_q == LAST_IDX) begin
						iss_done_q <= 1'b1;
					end
				end
				if (cmp_hit) begin
					hit_q <= 1'b1;
				end
				if (cmp_free) begin
					free_q <= 1'b1;
				end
			end
			if (cmd.calc) begin
				pass_q <= (delay_d >= {{(TIME_W-CFG_W){1'b0}}, min_delay_q});
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_task_id   = out_task_id_q;
	assign delay_ns      = delay_ns_q;
	assign event_time_ns = event_time_ns_q;

endmodule

>>> rtl/wrlt_checker.sv
// Port-level assertions for the wakeup-to-run latency table top level.
// Bound to wakeup_to_run_latency_table_top; depends on wrlt_pkg.
`timescale 1ns / 1ps

module wrlt_checker
	import wrlt_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [TASK_W-1:0] out_task_id,
	input logic [TIME_W-1:0] delay_ns,
	input logic [TIME_W-1:0] event_time_ns
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Output transaction dropped before it was taken.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			$stable(out_task_id) && $stable(delay_ns) && $stable(event_time_ns))
		else $error("Output payload changed while stalled.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("Input accepted while a table search was in progress.");

	a_report_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("Report appeared while the block was idle.");

endmodule

bind wakeup_to_run_latency_table_top wrlt_checker u_wrlt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.out_task_id   (out_task_id),
	.delay_ns      (delay_ns),
	.event_time_ns (event_time_ns)
);
